// ----- design/rmq_pkg.sv -----
// Package for the rotation-matrix-to-quaternion block.
// Holds the branch select type shared by the pipeline stages; no dependencies.
`default_nettype none

package rmq_pkg;

    // Which quaternion component is solved from the square root.
    typedef enum logic [1:0] {
        SEL_W,
        SEL_X,
        SEL_Y,
        SEL_Z
    } sel_t;

endpackage

`default_nettype wire

// ----- design/rmq_mat_if.sv -----
// Valid/ready channel that carries one 3x3 matrix item.
// No dependencies.
`default_nettype none

interface rmq_mat_if #(
    parameter int DATA_WIDTH = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] elem_r0c0;
    logic signed [DATA_WIDTH-1:0] elem_r0c1;
    logic signed [DATA_WIDTH-1:0] elem_r0c2;
    logic signed [DATA_WIDTH-1:0] elem_r1c0;
    logic signed [DATA_WIDTH-1:0] elem_r1c1;
    logic signed [DATA_WIDTH-1:0] elem_r1c2;
    logic signed [DATA_WIDTH-1:0] elem_r2c0;
    logic signed [DATA_WIDTH-1:0] elem_r2c1;
    logic signed [DATA_WIDTH-1:0] elem_r2c2;

    modport source (
        output valid, elem_r0c0, elem_r0c1, elem_r0c2, elem_r1c0, elem_r1c1,
               elem_r1c2, elem_r2c0, elem_r2c1, elem_r2c2,
        input  ready
    );

    modport sink (
        input  valid, elem_r0c0, elem_r0c1, elem_r0c2, elem_r1c0, elem_r1c1,
               elem_r1c2, elem_r2c0, elem_r2c1, elem_r2c2,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/rmq_quat_if.sv -----
// Valid/ready channel that carries one quaternion item.
// No dependencies.
`default_nettype none

interface rmq_quat_if #(
    parameter int DATA_WIDTH = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] quat_w;
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;

    modport source (
        output valid, quat_w, quat_x, quat_y, quat_z,
        input  ready
    );

    modport sink (
        input  valid, quat_w, quat_x, quat_y, quat_z,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/rmq_isqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
// Carries a sideband word and a valid bit alongside; no package dependency.
`default_nettype none

module rmq_isqrt #(
    parameter int VAL_W = 32,
    parameter int SB_W  = 8,
    localparam int ROOT_W = (VAL_W + 1) / 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              valid_in,
    input  wire logic [VAL_W-1:0]  val_in,
    input  wire logic [SB_W-1:0]   sb_in,
    output logic                   valid_out,
    output logic [ROOT_W-1:0]      root_out,
    output logic [SB_W-1:0]        sb_out
);

    localparam int PAD_W = 2 * ROOT_W;

    logic [ROOT_W+1:0] rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [PAD_W-1:0]  val_reg  [ROOT_W];
    logic [SB_W-1:0]   sb_reg   [ROOT_W];
    logic              vld_reg  [ROOT_W];

    logic [PAD_W-1:0] val_pad;

    assign val_pad = PAD_W'(val_in);

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [ROOT_W+1:0] rem_cur;
        logic [ROOT_W-1:0] root_cur;
        logic [PAD_W-1:0]  val_cur;
        logic [SB_W-1:0]   sb_cur;
        logic              vld_cur;
        logic [ROOT_W+1:0] rem_sh;
        logic [ROOT_W+1:0] trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign val_cur  = val_pad;
            assign sb_cur   = sb_in;
            assign vld_cur  = valid_in;
        end else begin : g_next
            assign rem_cur  = rem_reg[k-1];
            assign root_cur = root_reg[k-1];
            assign val_cur  = val_reg[k-1];
            assign sb_cur   = sb_reg[k-1];
            assign vld_cur  = vld_reg[k-1];
        end

        // Bring down the next two bits and try the next root bit.
        assign rem_sh = {rem_cur[ROOT_W-1:0], val_cur[PAD_W-1 -: 2]};
        assign trial  = {root_cur, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {root_cur[ROOT_W-2:0], ge};
                val_reg[k]  <= {val_cur[PAD_W-3:0], 2'b00};
                sb_reg[k]   <= sb_cur;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_cur;
            end
        end
    end

    assign valid_out = vld_reg[ROOT_W-1];
    assign root_out  = root_reg[ROOT_W-1];
    assign sb_out    = sb_reg[ROOT_W-1];

endmodule

`default_nettype wire

// ----- design/rmq_div.sv -----
// Pipelined restoring divider: an overflow check stage, then one quotient
// bit per register stage. Carries a sideband word and a valid bit; no package use.
`default_nettype none

module rmq_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 17,
    parameter int QUO_W = 16,
    parameter int SB_W  = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             valid_in,
    input  wire logic [NUM_W-1:0] num_in,
    input  wire logic [DEN_W-1:0] den_in,
    input  wire logic [SB_W-1:0]  sb_in,
    output logic                  valid_out,
    output logic [QUO_W-1:0]      quo_out,
    output logic                  ovf_out,
    output logic [SB_W-1:0]       sb_out
);

    localparam int HI_W = NUM_W - QUO_W;
    localparam int CW   = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [DEN_W-1:0] rem_reg [QUO_W+1];
    logic [QUO_W-1:0] low_reg [QUO_W+1];
    logic [QUO_W-1:0] quo_reg [QUO_W+1];
    logic [DEN_W-1:0] den_reg [QUO_W+1];
    logic             ovf_reg [QUO_W+1];
    logic [SB_W-1:0]  sb_reg  [QUO_W+1];
    logic             vld_reg [QUO_W+1];

    // The quotient fits in QUO_W bits exactly when the high numerator part
    // is below the divisor; that part is then the starting remainder.
    logic [CW-1:0] hi_x;
    logic [CW-1:0] den_x;

    assign hi_x  = CW'(num_in[NUM_W-1:QUO_W]);
    assign den_x = CW'(den_in);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= hi_x[DEN_W-1:0];
            low_reg[0] <= num_in[QUO_W-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den_in;
            ovf_reg[0] <= (hi_x >= den_x);
            sb_reg[0]  <= sb_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= valid_in;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
        logic [DEN_W:0] rem_sh;
        logic [DEN_W:0] dif;
        logic           ge;

        // Shift in one numerator bit and subtract where the divisor fits.
        assign rem_sh = {rem_reg[k-1], low_reg[k-1][QUO_W-1]};
        assign dif    = rem_sh - {1'b0, den_reg[k-1]};
        assign ge     = (rem_sh >= {1'b0, den_reg[k-1]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                low_reg[k] <= {low_reg[k-1][QUO_W-2:0], 1'b0};
                quo_reg[k] <= {quo_reg[k-1][QUO_W-2:0], ge};
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                sb_reg[k]  <= sb_reg[k-1];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign valid_out = vld_reg[QUO_W];
    assign quo_out   = quo_reg[QUO_W];
    assign ovf_out   = ovf_reg[QUO_W];
    assign sb_out    = sb_reg[QUO_W];

endmodule

`default_nettype wire

// ----- design/rotation_matrix_to_quaternion.sv -----
// Rotation matrix to quaternion converter, top level.
// Depends on rmq_pkg, rmq_mat_if, rmq_quat_if, rmq_isqrt and rmq_div.
//
// Usage: mat_in takes one 3x3 matrix item (signed fixed point, FRAC_BITS
// fraction bits) per valid/ready handshake; quat_out gives one quaternion
// item (w, x, y, z) per matrix, in order, saturated to the data range.
// A positive trace solves w first; otherwise the largest diagonal entry
// picks x, y or z. The chosen component is half the root of its diagonal
// sum plus one; the others are pair sums or differences over twice the root.
//
// The square root gives ROOT_W = (DATA_WIDTH + FRAC_BITS + 3) / 2 bits and
// takes one stage per root bit; the three dividers take one stage per
// quotient bit plus an overflow stage.
// Throughput: one item per cycle while the output is not stalled.
// Stall: the whole pipeline holds while the output register is full and
// quat_out.ready is low; mat_in.ready is low in that case.
// Reset: clears all valid bits; the pipeline starts empty.
`default_nettype none

module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  wire logic clk,
    input  wire logic rst_n,
    rmq_mat_if.sink   mat_in,
    rmq_quat_if.source quat_out
);

    localparam int DW   = DATA_WIDTH;
    localparam int SW   = DW + 3;
    localparam int UW   = DW + 2;
    localparam int VW   = UW + FRAC_BITS;
    localparam int RW   = (VW + 1) / 2;
    localparam int PW   = DW + 1;
    localparam int NW   = DW + FRAC_BITS + 2;
    localparam int DVW  = RW + 1;
    localparam int HW   = RW - 1;
    localparam int XW   = (HW > DW) ? HW : DW;
    localparam int SBQ  = 2 + 3 * PW;
    localparam int SB0  = HW + 4;

    localparam logic signed [SW-1:0] ONE     = SW'(1) << FRAC_BITS;
    localparam logic signed [DW-1:0] OUT_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] OUT_MIN = {1'b1, {(DW-1){1'b0}}};

    logic en;

    // Map a divider result onto the saturated signed output.
    function automatic logic signed [DW-1:0] slot_value(
        input logic [DW-1:0] q,
        input logic          ovf,
        input logic          neg,
        input logic          zero
    );
        logic signed [DW-1:0] v;
        if (zero)
            v = '0;
        else if (ovf)
            v = neg ? OUT_MIN : OUT_MAX;
        else if (!neg && (q > DW'(OUT_MAX)))
            v = OUT_MAX;
        else if (neg && (q > DW'(OUT_MIN)))
            v = OUT_MIN;
        else
            v = neg ? -$signed(q) : $signed(q);
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Stage A: trace, branch choice and the six off-diagonal pairs.
    // ------------------------------------------------------------------
    logic signed [SW-1:0] trace_a;
    rmq_pkg::sel_t        sel_a;

    assign trace_a = SW'(mat_in.elem_r0c0) + SW'(mat_in.elem_r1c1) + SW'(mat_in.elem_r2c2);

    always_comb
    begin
        priority if (trace_a > 0)
            sel_a = rmq_pkg::SEL_W;
        else if ((mat_in.elem_r0c0 > mat_in.elem_r1c1) && (mat_in.elem_r0c0 > mat_in.elem_r2c2))
            sel_a = rmq_pkg::SEL_X;
        else if (mat_in.elem_r1c1 > mat_in.elem_r2c2)
            sel_a = rmq_pkg::SEL_Y;
        else
            sel_a = rmq_pkg::SEL_Z;
    end

    rmq_pkg::sel_t        sel_a_reg;
    logic signed [DW-1:0] d00_reg, d11_reg, d22_reg;
    logic signed [PW-1:0] dx_reg, dy_reg, dz_reg, sxy_reg, sxz_reg, syz_reg;
    logic                 vld_a_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_a_reg <= sel_a;
            d00_reg   <= mat_in.elem_r0c0;
            d11_reg   <= mat_in.elem_r1c1;
            d22_reg   <= mat_in.elem_r2c2;
            dx_reg    <= PW'(mat_in.elem_r2c1) - PW'(mat_in.elem_r1c2);
            dy_reg    <= PW'(mat_in.elem_r0c2) - PW'(mat_in.elem_r2c0);
            dz_reg    <= PW'(mat_in.elem_r1c0) - PW'(mat_in.elem_r0c1);
            sxy_reg   <= PW'(mat_in.elem_r0c1) + PW'(mat_in.elem_r1c0);
            sxz_reg   <= PW'(mat_in.elem_r0c2) + PW'(mat_in.elem_r2c0);
            syz_reg   <= PW'(mat_in.elem_r1c2) + PW'(mat_in.elem_r2c1);
        end
    end

    // ------------------------------------------------------------------
    // Stage B: diagonal sum for the branch, clamp, route pairs to slots.
    // Slots a, b, c feed the three non-chosen components in w, x, y, z order.
    // ------------------------------------------------------------------
    logic signed [SW-1:0] s_b;
    logic [UW-1:0]        su_b;
    logic signed [PW-1:0] pa_b, pb_b, pc_b;

    always_comb
    begin
        unique case (sel_a_reg)
            rmq_pkg::SEL_W:
            begin
                s_b  = ONE + SW'(d00_reg) + SW'(d11_reg) + SW'(d22_reg);
                pa_b = dx_reg;
                pb_b = dy_reg;
                pc_b = dz_reg;
            end
            rmq_pkg::SEL_X:
            begin
                s_b  = ONE + SW'(d00_reg) - SW'(d11_reg) - SW'(d22_reg);
                pa_b = dx_reg;
                pb_b = sxy_reg;
                pc_b = sxz_reg;
            end
            rmq_pkg::SEL_Y:
            begin
                s_b  = ONE + SW'(d11_reg) - SW'(d00_reg) - SW'(d22_reg);
                pa_b = dy_reg;
                pb_b = sxy_reg;
                pc_b = syz_reg;
            end
            default:
            begin
                s_b  = ONE + SW'(d22_reg) - SW'(d00_reg) - SW'(d11_reg);
                pa_b = dz_reg;
                pb_b = sxz_reg;
                pc_b = syz_reg;
            end
        endcase
        su_b = s_b[SW-1] ? '0 : s_b[UW-1:0];
    end

    rmq_pkg::sel_t        sel_b_reg;
    logic [UW-1:0]        s_reg;
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg;
    logic                 vld_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_b_reg <= sel_a_reg;
            s_reg     <= su_b;
            pa_reg    <= pa_b;
            pb_reg    <= pb_b;
            pc_reg    <= pc_b;
        end
    end

    // ------------------------------------------------------------------
    // Square root of the diagonal sum scaled into the fixed-point format.
    // ------------------------------------------------------------------
    logic            sq_valid;
    logic [RW-1:0]   sq_root;
    logic [SBQ-1:0]  sq_sb;

    rmq_isqrt #(
        .VAL_W (VW),
        .SB_W  (SBQ)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (vld_b_reg),
        .val_in    ({s_reg, {FRAC_BITS{1'b0}}}),
        .sb_in     ({sel_b_reg, pa_reg, pb_reg, pc_reg}),
        .valid_out (sq_valid),
        .root_out  (sq_root),
        .sb_out    (sq_sb)
    );

    // ------------------------------------------------------------------
    // Stage C: signs, magnitudes and rounded numerators for the dividers.
    // ------------------------------------------------------------------
    rmq_pkg::sel_t        sel_c;
    logic signed [PW-1:0] pa_c, pb_c, pc_c;
    logic [PW-1:0]        ma_c, mb_c, mc_c;
    logic [NW-1:0]        r_ext;

    assign sel_c = rmq_pkg::sel_t'(sq_sb[SBQ-1 -: 2]);
    assign pa_c  = $signed(sq_sb[3*PW-1 -: PW]);
    assign pb_c  = $signed(sq_sb[2*PW-1 -: PW]);
    assign pc_c  = $signed(sq_sb[PW-1:0]);
    assign ma_c  = pa_c[PW-1] ? PW'(-pa_c) : PW'(pa_c);
    assign mb_c  = pb_c[PW-1] ? PW'(-pb_c) : PW'(pb_c);
    assign mc_c  = pc_c[PW-1] ? PW'(-pc_c) : PW'(pc_c);
    assign r_ext = NW'(sq_root);

    rmq_pkg::sel_t  sel_c_reg;
    logic [NW-1:0]  na_reg, nb_reg, nc_reg;
    logic [DVW-1:0] den_reg;
    logic [HW-1:0]  half_reg;
    logic           zero_reg;
    logic           sa_reg, sb_reg, sc_reg;
    logic           vld_c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_c_reg <= sel_c;
            na_reg    <= {1'b0, ma_c, {FRAC_BITS{1'b0}}} + r_ext;
            nb_reg    <= {1'b0, mb_c, {FRAC_BITS{1'b0}}} + r_ext;
            nc_reg    <= {1'b0, mc_c, {FRAC_BITS{1'b0}}} + r_ext;
            den_reg   <= {sq_root, 1'b0};
            half_reg  <= sq_root[RW-1:1];
            zero_reg  <= (sq_root == '0);
            sa_reg    <= pa_c[PW-1];
            sb_reg    <= pb_c[PW-1];
            sc_reg    <= pc_c[PW-1];
        end
    end

    // ------------------------------------------------------------------
    // Three dividers, one per slot; slot a also carries the branch data.
    // ------------------------------------------------------------------
    logic           da_valid, db_valid, dc_valid;
    logic [DW-1:0]  qa, qb, qc;
    logic           oa, ob, oc;
    logic [SB0-1:0] da_sb;
    logic           db_sb, dc_sb;

    rmq_div #(
        .NUM_W (NW),
        .DEN_W (DVW),
        .QUO_W (DW),
        .SB_W  (SB0)
    ) u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (vld_c_reg),
        .num_in    (na_reg),
        .den_in    (den_reg),
        .sb_in     ({sel_c_reg, half_reg, zero_reg, sa_reg}),
        .valid_out (da_valid),
        .quo_out   (qa),
        .ovf_out   (oa),
        .sb_out    (da_sb)
    );

    rmq_div #(
        .NUM_W (NW),
        .DEN_W (DVW),
        .QUO_W (DW),
        .SB_W  (1)
    ) u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (vld_c_reg),
        .num_in    (nb_reg),
        .den_in    (den_reg),
        .sb_in     (sb_reg),
        .valid_out (db_valid),
        .quo_out   (qb),
        .ovf_out   (ob),
        .sb_out    (db_sb)
    );

    rmq_div #(
        .NUM_W (NW),
        .DEN_W (DVW),
        .QUO_W (DW),
        .SB_W  (1)
    ) u_div_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (vld_c_reg),
        .num_in    (nc_reg),
        .den_in    (den_reg),
        .sb_in     (sc_reg),
        .valid_out (dc_valid),
        .quo_out   (qc),
        .ovf_out   (oc),
        .sb_out    (dc_sb)
    );

    // ------------------------------------------------------------------
    // Output stage: saturate and place each slot on its component.
    // ------------------------------------------------------------------
    rmq_pkg::sel_t        sel_o;
    logic [HW-1:0]        half_o;
    logic                 zero_o;
    logic [XW-1:0]        half_x;
    logic signed [DW-1:0] half_v, va, vb, vc;
    logic signed [DW-1:0] w_o, x_o, y_o, z_o;

    assign sel_o  = rmq_pkg::sel_t'(da_sb[SB0-1 -: 2]);
    assign half_o = da_sb[HW+1:2];
    assign zero_o = da_sb[1];
    assign half_x = XW'(half_o);
    assign half_v = (half_x > XW'(OUT_MAX)) ? OUT_MAX : $signed(half_x[DW-1:0]);
    assign va     = slot_value(qa, oa, da_sb[0], zero_o);
    assign vb     = slot_value(qb, ob, db_sb, zero_o);
    assign vc     = slot_value(qc, oc, dc_sb, zero_o);

    always_comb
    begin
        unique case (sel_o)
            rmq_pkg::SEL_W:
            begin
                w_o = half_v; x_o = va; y_o = vb; z_o = vc;
            end
            rmq_pkg::SEL_X:
            begin
                w_o = va; x_o = half_v; y_o = vb; z_o = vc;
            end
            rmq_pkg::SEL_Y:
            begin
                w_o = va; x_o = vb; y_o = half_v; z_o = vc;
            end
            default:
            begin
                w_o = va; x_o = vb; y_o = vc; z_o = half_v;
            end
        endcase
    end

    logic signed [DW-1:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic                 zero_out_reg;
    logic                 out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qw_reg       <= w_o;
            qx_reg       <= x_o;
            qy_reg       <= y_o;
            qz_reg       <= z_o;
            zero_out_reg <= zero_o;
        end
    end

    // Valid bits of the local stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg     <= 1'b0;
            vld_b_reg     <= 1'b0;
            vld_c_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg     <= mat_in.valid;
            vld_b_reg     <= vld_a_reg;
            vld_c_reg     <= sq_valid;
            out_valid_reg <= da_valid;
        end
    end

    // The pipeline moves whenever the output register can be refilled.
    assign en             = !out_valid_reg || quat_out.ready;
    assign mat_in.ready   = en;
    assign quat_out.valid = out_valid_reg;
    assign quat_out.quat_w = qw_reg;
    assign quat_out.quat_x = qx_reg;
    assign quat_out.quat_y = qy_reg;
    assign quat_out.quat_z = qz_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_div_valid_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (da_valid == db_valid) && (da_valid == dc_valid))
        else $error("divider valid bits out of step");

    a_zero_root_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && zero_out_reg) |->
        (qw_reg == '0 && qx_reg == '0 && qy_reg == '0 && qz_reg == '0))
        else $error("zero root gave a nonzero quaternion");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !quat_out.ready) |=> (out_valid_reg && $stable(qw_reg)
        && $stable(qz_reg) && !$past(mat_in.ready)))
        else $error("output register changed under stall");

endmodule

`default_nettype wire
